// File: src/dijet_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dijet_pkg
// Shared types, constants and the jet cut function of the dijet event selector.
// ----------------------------------------------------------------------------
package dijet_pkg;

	// register indexes on the configuration port
	localparam logic [3:0] REG_MIN_PT          = 4'd0;
	localparam logic [3:0] REG_MAX_ABS_ETA     = 4'd1;
	localparam logic [3:0] REG_MAX_NHF         = 4'd2;
	localparam logic [3:0] REG_MAX_NEF         = 4'd3;
	localparam logic [3:0] REG_MIN_CHF         = 4'd4;
	localparam logic [3:0] REG_MAX_CEF         = 4'd5;
	localparam logic [3:0] REG_MIN_CONST       = 4'd6;
	localparam logic [3:0] REG_MIN_CHARGED_MUL = 4'd7;

	// |eta| < 2.4 in units of 1/256
	localparam logic [11:0] TRACKER_ABS_ETA_MAX = 12'd614;
	// pi and 2*pi in units of 1/1024
	localparam logic signed [14:0] PI_Q     = 15'sd3217;
	localparam logic signed [14:0] TWO_PI_Q = 15'sd6434;
	// |pi - |dphi|| < 1 rad  <=>  |dphi| > pi - 1024
	localparam logic [14:0] B2B_MIN_ABS_DPHI = 15'd2193;

	typedef struct packed {
		logic              vld;
		logic [15:0]       pt;
		logic signed [11:0] eta;
		logic signed [12:0] phi;
		logic [10:0]       neutral_hadron_frac;
		logic [10:0]       neutral_em_frac;
		logic [10:0]       charged_hadron_frac;
		logic [10:0]       charged_em_frac;
		logic [7:0]        constituent_count;
		logic [7:0]        charged_mult;
	} jet_t;

	// candidate handed along the chain; displaced marks a jet pushed down by a
	// higher one, which the next cell must take unconditionally
	typedef struct packed {
		jet_t jet;
		logic displaced;
	} cand_t;

	typedef struct packed {
		logic [15:0] min_pt;
		logic [10:0] max_abs_eta;
		logic [10:0] max_neutral_hadron_frac;
		logic [10:0] max_neutral_em_frac;
		logic [10:0] min_charged_hadron_frac;
		logic [10:0] max_charged_em_frac;
		logic [7:0]  min_constituents;
		logic [7:0]  min_charged_mult;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		min_pt:                  16'd480,
		max_abs_eta:             11'd1280,
		max_neutral_hadron_frac: 11'd1024,
		max_neutral_em_frac:     11'd1024,
		min_charged_hadron_frac: 11'd0,
		max_charged_em_frac:     11'd1024,
		min_constituents:        8'd1,
		min_charged_mult:        8'd0
	};

	function automatic logic jet_passes(jet_t j, cfg_t c);
		logic [11:0] aeta;
		logic base;
		logic trk;
		aeta = j.eta[11] ? 12'(-j.eta) : 12'(j.eta);
		base = (j.pt > c.min_pt) && (aeta < {1'b0, c.max_abs_eta})
			&& (j.neutral_hadron_frac < c.max_neutral_hadron_frac)
			&& (j.neutral_em_frac < c.max_neutral_em_frac)
			&& (j.constituent_count > c.min_constituents);
		// charged cuts only inside the tracker acceptance
		trk = (aeta <= TRACKER_ABS_ETA_MAX);
		return base && (!trk || ((j.charged_em_frac < c.max_charged_em_frac)
			&& (j.charged_hadron_frac > c.min_charged_hadron_frac)
			&& (j.charged_mult > c.min_charged_mult)));
	endfunction

endpackage
`default_nettype wire

// File: src/dijet_event_selector_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dijet_event_selector_top
// Back-to-back dijet event selection over a stream of jets.
// ----------------------------------------------------------------------------
// Jets enter on the in_ channel, one per transfer, with last_jet marking the
// end of an event. A chain of two cells keeps the leading and second jet;
// a jet of zero momentum leaves them untouched. The transfer of the last jet
// snapshots both cells and empties them, so the next event may start in the
// very next cycle. One result per event leaves on the out_ channel through
// the registered snapshot, the cut stage and the output register.
// Throughput is one jet per cycle while no last jet is stalled, set by the
// single compare-and-shift step of the cell chain.
// A stalled receiver holds the result; jets that are not last keep flowing,
// and a last jet is stalled only when the snapshot stage and the stages
// behind it are all full and the receiver stalls. Configuration writes are
// taken every cycle (cfg_ready is tied high) and are meant for an idle block.
// Reset empties the chain and the pipeline and loads the default cuts.
// ----------------------------------------------------------------------------
module dijet_event_selector_top
	import dijet_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output      logic               cfg_ready,
	input  wire logic [3:0]         cfg_index,
	input  wire logic [15:0]        cfg_data,
	input  wire logic               in_valid,
	output      logic               in_stall,
	input  wire logic [15:0]        jet_pt,
	input  wire logic signed [11:0] jet_eta,
	input  wire logic signed [12:0] jet_phi,
	input  wire logic [10:0]        neutral_hadron_frac,
	input  wire logic [10:0]        neutral_em_frac,
	input  wire logic [10:0]        charged_hadron_frac,
	input  wire logic [10:0]        charged_em_frac,
	input  wire logic [7:0]         constituent_count,
	input  wire logic [7:0]         charged_mult,
	input  wire logic               last_jet,
	output      logic               out_valid,
	input  wire logic               out_stall,
	output      logic               dijet_accept,
	output      logic [15:0]        lead_pt_out,
	output      logic [15:0]        second_pt_out
);

	cfg_t  cfg_q;
	cand_t lead_in;
	cand_t lead_out;
	jet_t  lead_held;
	jet_t  lead_upd;
	jet_t  second_held;
	jet_t  second_upd;
	logic  snap_ready;
	logic  in_xfer;
	logic  end_event;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MIN_PT:          cfg_q.min_pt                  <= cfg_data;
				REG_MAX_ABS_ETA:     cfg_q.max_abs_eta             <= cfg_data[10:0];
				REG_MAX_NHF:         cfg_q.max_neutral_hadron_frac <= cfg_data[10:0];
				REG_MAX_NEF:         cfg_q.max_neutral_em_frac     <= cfg_data[10:0];
				REG_MIN_CHF:         cfg_q.min_charged_hadron_frac <= cfg_data[10:0];
				REG_MAX_CEF:         cfg_q.max_charged_em_frac     <= cfg_data[10:0];
				REG_MIN_CONST:       cfg_q.min_constituents        <= cfg_data[7:0];
				REG_MIN_CHARGED_MUL: cfg_q.min_charged_mult        <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// only a last jet needs room in the end-of-event pipeline
	assign in_stall  = last_jet && !snap_ready;
	assign in_xfer   = in_valid && !in_stall;
	assign end_event = in_xfer && last_jet;

	always_comb begin
		lead_in.jet.vld                 = (jet_pt != 16'd0);
		lead_in.jet.pt                  = jet_pt;
		lead_in.jet.eta                 = jet_eta;
		lead_in.jet.phi                 = jet_phi;
		lead_in.jet.neutral_hadron_frac = neutral_hadron_frac;
		lead_in.jet.neutral_em_frac     = neutral_em_frac;
		lead_in.jet.charged_hadron_frac = charged_hadron_frac;
		lead_in.jet.charged_em_frac     = charged_em_frac;
		lead_in.jet.constituent_count   = constituent_count;
		lead_in.jet.charged_mult        = charged_mult;
		lead_in.displaced               = 1'b0;
	end

	dijet_cell u_lead (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (in_xfer),
		.clr      (last_jet),
		.cand_in  (lead_in),
		.cand_out (lead_out),
		.held     (lead_held),
		.held_upd (lead_upd)
	);

	dijet_cell u_second (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (in_xfer),
		.clr      (last_jet),
		.cand_in  (lead_out),
		.cand_out (),
		.held     (second_held),
		.held_upd (second_upd)
	);

	dijet_cut u_cut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.snap_take     (end_event),
		.snap_lead     (lead_upd),
		.snap_second   (second_upd),
		.snap_ready    (snap_ready),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.dijet_accept  (dijet_accept),
		.lead_pt_out   (lead_pt_out),
		.second_pt_out (second_pt_out)
	);

	a_second_needs_lead: assert property (@(posedge clk) disable iff (!arst_n)
		second_held.vld |-> lead_held.vld)
		else $error("second place filled without a leader");

	a_chain_order: assert property (@(posedge clk) disable iff (!arst_n)
		second_held.vld |-> second_held.pt <= lead_held.pt)
		else $error("second jet above leader");

	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		end_event |=> !lead_held.vld && !second_held.vld)
		else $error("jet state not cleared after last jet");

endmodule
`default_nettype wire

// File: src/dijet_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dijet_cell
// One place of the top-two chain: keeps a jet, takes a higher or displaced
// candidate (any one while empty) and hands the loser on to the next cell.
// ----------------------------------------------------------------------------
module dijet_cell
	import dijet_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  en,
	input  wire logic  clr,
	input  wire cand_t cand_in,
	output      cand_t cand_out,
	output      jet_t  held,
	output      jet_t  held_upd
);

	logic vld_q;
	jet_t jet_q;
	logic win;

	always_comb begin
		held     = jet_q;
		held.vld = vld_q;
	end

	assign win = cand_in.jet.vld
		&& (cand_in.displaced || !vld_q || (cand_in.jet.pt > jet_q.pt));

	always_comb begin
		if (win) begin
			held_upd           = cand_in.jet;
			cand_out.jet       = held;
			cand_out.displaced = 1'b1;
		end else begin
			held_upd = held;
			cand_out = cand_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= held_upd.vld && !clr;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			jet_q <= held_upd;
		end
	end

endmodule
`default_nettype wire

// File: src/dijet_cut.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dijet_cut
// End-of-event stage: snapshot of the two kept jets, quality cuts and the
// back-to-back azimuth test, with an output register toward the receiver.
// ----------------------------------------------------------------------------
module dijet_cut
	import dijet_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire logic        snap_take,
	input  wire jet_t        snap_lead,
	input  wire jet_t        snap_second,
	output      logic        snap_ready,
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic        dijet_accept,
	output      logic [15:0] lead_pt_out,
	output      logic [15:0] second_pt_out
);

	logic        snap_v_s1;
	jet_t        lead_s1;
	jet_t        second_s1;

	logic        res_v_s2;
	logic        ok_s2;
	logic signed [14:0] dphi_s2;
	logic [15:0] lead_pt_s2;
	logic [15:0] second_pt_s2;

	logic        out_valid_q;
	logic        accept_q;
	logic [15:0] lead_pt_q;
	logic [15:0] second_pt_q;

	logic        ready_s2;
	logic        ready_out;
	logic signed [14:0] dphi_raw;
	logic signed [14:0] dphi_wrap;
	logic [14:0] dphi_abs;
	logic        accept_d;

	assign ready_out  = !out_valid_q || !out_stall;
	assign ready_s2   = !res_v_s2 || ready_out;
	assign snap_ready = !snap_v_s1 || ready_s2;

	// azimuth difference wrapped once into [-pi, pi]
	always_comb begin
		dphi_raw = 15'(lead_s1.phi) - 15'(second_s1.phi);
		if (dphi_raw > PI_Q) begin
			dphi_wrap = dphi_raw - TWO_PI_Q;
		end else if (dphi_raw < -PI_Q) begin
			dphi_wrap = dphi_raw + TWO_PI_Q;
		end else begin
			dphi_wrap = dphi_raw;
		end
	end

	assign dphi_abs = dphi_s2[14] ? 15'(-dphi_s2) : 15'(dphi_s2);
	assign accept_d = ok_s2 && (dphi_abs > B2B_MIN_ABS_DPHI);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_v_s1   <= 1'b0;
			res_v_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (snap_ready) begin
				snap_v_s1 <= snap_take;
			end
			if (ready_s2) begin
				res_v_s2 <= snap_v_s1;
			end
			if (ready_out) begin
				out_valid_q <= res_v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (snap_ready && snap_take) begin
			lead_s1   <= snap_lead;
			second_s1 <= snap_second;
		end
		if (ready_s2) begin
			ok_s2 <= lead_s1.vld && second_s1.vld
				&& jet_passes(lead_s1, cfg) && jet_passes(second_s1, cfg);
			dphi_s2      <= dphi_wrap;
			lead_pt_s2   <= lead_s1.pt;
			second_pt_s2 <= second_s1.pt;
		end
		if (ready_out) begin
			accept_q    <= accept_d;
			lead_pt_q   <= accept_d ? lead_pt_s2 : 16'd0;
			second_pt_q <= accept_d ? second_pt_s2 : 16'd0;
		end
	end

	assign out_valid     = out_valid_q;
	assign dijet_accept  = accept_q;
	assign lead_pt_out   = lead_pt_q;
	assign second_pt_out = second_pt_q;

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !accept_q |-> lead_pt_q == 16'd0 && second_pt_q == 16'd0)
		else $error("rejected event with nonzero momentum");

	a_accept_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && accept_q |-> lead_pt_q >= second_pt_q && second_pt_q != 16'd0)
		else $error("accepted event with bad momentum order");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_v_s2 && !ready_out |=> res_v_s2 && $stable(accept_d))
		else $error("result lost while output blocked");

endmodule
`default_nettype wire

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the dijet event selector.
// ----------------------------------------------------------------------------
// Jets are driven one transfer at a time and folded into a local model of the
// top-two selection and the event cuts. Each event verdict on the result
// channel is compared field by field with the oldest predicted verdict.
// Directed events cover ties, zero-momentum jets, short events and the cut
// boundaries. Random events follow under several cut settings and idle/stall
// mixes, and one long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module tb_top
	import dijet_pkg::*;
();

	localparam int CLK_HALF = 6;
	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_WAIT = 3000;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int PI_FX = 3217;
	localparam int TWO_PI_FX = 6434;
	localparam int B2B_TOL = 1024;
	localparam int TRACKER_ETA = 614;
	localparam int ETA_SPAN = 1280;
	localparam logic [3:0] REG_FIRST_UNUSED = 4'd8;
	localparam logic [3:0] REG_LAST_INDEX = 4'hF;

	typedef struct packed {
		logic        accept;
		logic [15:0] lead_pt;
		logic [15:0] second_pt;
	} verdict_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [3:0]         cfg_index;
	logic [15:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic [15:0]        jet_pt;
	logic signed [11:0] jet_eta;
	logic signed [12:0] jet_phi;
	logic [10:0]        neutral_hadron_frac;
	logic [10:0]        neutral_em_frac;
	logic [10:0]        charged_hadron_frac;
	logic [10:0]        charged_em_frac;
	logic [7:0]         constituent_count;
	logic [7:0]         charged_mult;
	logic               last_jet;
	logic               out_valid;
	logic               out_stall;
	logic               dijet_accept;
	logic [15:0]        lead_pt_out;
	logic [15:0]        second_pt_out;

	cfg_t     cuts;
	jet_t     lead_jet;
	jet_t     second_jet;
	verdict_t expected_verdicts[$];
	int       error_count;
	int       jets_sent;
	int       idle_pct;
	int       stall_pct;
	int       hold_left;

	dijet_event_selector_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.jet_pt(jet_pt),
		.jet_eta(jet_eta),
		.jet_phi(jet_phi),
		.neutral_hadron_frac(neutral_hadron_frac),
		.neutral_em_frac(neutral_em_frac),
		.charged_hadron_frac(charged_hadron_frac),
		.charged_em_frac(charged_em_frac),
		.constituent_count(constituent_count),
		.charged_mult(charged_mult),
		.last_jet(last_jet),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.dijet_accept(dijet_accept),
		.lead_pt_out(lead_pt_out),
		.second_pt_out(second_pt_out)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		#(LIMIT_CYCLES * 2 * CLK_HALF);
		$display("Test completed with failures");
		$finish;
	end

	task automatic report_error(string msg);
		$display("ERROR at %0t: %s", $time, msg);
		error_count++;
	endtask

	task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
		if (got !== want) begin
			report_error($sformatf("%s mismatch: got %0d, expected %0d", name, got, want));
		end
	endtask

	function automatic logic jet_quality_ok(jet_t j);
		int aeta;
		aeta = $signed(j.eta);
		if (aeta < 0) begin
			aeta = -aeta;
		end
		if (!(j.pt > cuts.min_pt && aeta < int'(cuts.max_abs_eta))) return 1'b0;
		if (!(j.neutral_hadron_frac < cuts.max_neutral_hadron_frac
				&& j.neutral_em_frac < cuts.max_neutral_em_frac
				&& j.constituent_count > cuts.min_constituents)) return 1'b0;
		// charged cuts only inside the tracker acceptance
		if (aeta <= TRACKER_ETA) begin
			return j.charged_em_frac < cuts.max_charged_em_frac
				&& j.charged_hadron_frac > cuts.min_charged_hadron_frac
				&& j.charged_mult > cuts.min_charged_mult;
		end
		return 1'b1;
	endfunction

	// fold one accepted jet into the top two; the last jet closes the event
	function automatic void predict_verdict(jet_t j, logic last);
		verdict_t v;
		int phi_a;
		int phi_b;
		int dphi;
		if (j.pt != 0) begin
			if (!lead_jet.vld || j.pt > lead_jet.pt) begin
				second_jet = lead_jet;
				lead_jet = j;
				lead_jet.vld = 1'b1;
			end else if (!second_jet.vld || j.pt > second_jet.pt) begin
				second_jet = j;
				second_jet.vld = 1'b1;
			end
		end
		if (last) begin
			v = '0;
			if (lead_jet.vld && second_jet.vld
					&& jet_quality_ok(lead_jet) && jet_quality_ok(second_jet)) begin
				phi_a = $signed(lead_jet.phi);
				phi_b = $signed(second_jet.phi);
				dphi = phi_a - phi_b;
				if (dphi > PI_FX) begin
					dphi -= TWO_PI_FX;
				end else if (dphi < -PI_FX) begin
					dphi += TWO_PI_FX;
				end
				if (dphi < 0) begin
					dphi = -dphi;
				end
				if (PI_FX - dphi < B2B_TOL) begin
					v.accept = 1'b1;
					v.lead_pt = lead_jet.pt;
					v.second_pt = second_jet.pt;
				end
			end
			expected_verdicts.push_back(v);
			lead_jet = '0;
			second_jet = '0;
		end
	endfunction

	// result side: random stalls, or a long hold-off when one is requested
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin : check_results
		verdict_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_verdicts.size() == 0) begin
				report_error($sformatf("unexpected result accept=%0b lead=%0d second=%0d",
					dijet_accept, lead_pt_out, second_pt_out));
			end else begin
				want = expected_verdicts.pop_front();
				check_field("dijet_accept", 16'(dijet_accept), 16'(want.accept));
				check_field("lead_pt_out", lead_pt_out, want.lead_pt);
				check_field("second_pt_out", second_pt_out, want.second_pt);
			end
		end
	end

	task automatic send_jet(jet_t j, logic last);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		jet_pt <= j.pt;
		jet_eta <= j.eta;
		jet_phi <= j.phi;
		neutral_hadron_frac <= j.neutral_hadron_frac;
		neutral_em_frac <= j.neutral_em_frac;
		charged_hadron_frac <= j.charged_hadron_frac;
		charged_em_frac <= j.charged_em_frac;
		constituent_count <= j.constituent_count;
		charged_mult <= j.charged_mult;
		last_jet <= last;
		do @(posedge clk); while (in_stall);
		predict_verdict(j, last);
		jets_sent++;
	endtask

	task automatic write_reg(logic [3:0] idx, logic [15:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_MIN_PT:          cuts.min_pt = data;
			REG_MAX_ABS_ETA:     cuts.max_abs_eta = data[10:0];
			REG_MAX_NHF:         cuts.max_neutral_hadron_frac = data[10:0];
			REG_MAX_NEF:         cuts.max_neutral_em_frac = data[10:0];
			REG_MIN_CHF:         cuts.min_charged_hadron_frac = data[10:0];
			REG_MAX_CEF:         cuts.max_charged_em_frac = data[10:0];
			REG_MIN_CONST:       cuts.min_constituents = data[7:0];
			REG_MIN_CHARGED_MUL: cuts.min_charged_mult = data[7:0];
			default: ;
		endcase
	endtask

	// unused upper data bits are random; an unmapped index is written as well
	task automatic write_cuts(cfg_t c);
		write_reg(REG_MIN_PT, c.min_pt);
		write_reg(REG_MAX_ABS_ETA, {5'($urandom), c.max_abs_eta});
		write_reg(REG_MAX_NHF, {5'($urandom), c.max_neutral_hadron_frac});
		write_reg(REG_MAX_NEF, {5'($urandom), c.max_neutral_em_frac});
		write_reg(REG_MIN_CHF, {5'($urandom), c.min_charged_hadron_frac});
		write_reg(REG_MAX_CEF, {5'($urandom), c.max_charged_em_frac});
		write_reg(REG_MIN_CONST, {8'($urandom), c.min_constituents});
		write_reg(REG_MIN_CHARGED_MUL, {8'($urandom), c.min_charged_mult});
		write_reg(4'($urandom_range(REG_LAST_INDEX, REG_FIRST_UNUSED)), 16'($urandom));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// stop offering jets, wait for every outstanding verdict, then let the block settle
	task automatic drain_results();
		int waited;
		waited = 0;
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_verdicts.size() != 0 && waited < DRAIN_WAIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_verdicts.size() != 0) begin
			report_error($sformatf("%0d event results never arrived", expected_verdicts.size()));
			expected_verdicts.delete();
		end
	endtask

	function automatic jet_t make_jet(int pt, int eta, int phi);
		jet_t j;
		j = '0;
		j.pt = 16'(pt);
		j.eta = 12'(eta);
		j.phi = 13'(phi);
		j.neutral_hadron_frac = 11'd100;
		j.neutral_em_frac = 11'd100;
		j.charged_hadron_frac = 11'd500;
		j.charged_em_frac = 11'd100;
		j.constituent_count = 8'd10;
		j.charged_mult = 8'd5;
		return j;
	endfunction

	function automatic jet_t plausible_jet(int pt_lo, int pt_hi);
		jet_t j;
		j = '0;
		j.pt = 16'($urandom_range(pt_hi, pt_lo));
		j.eta = 12'(int'($urandom_range(2 * ETA_SPAN)) - ETA_SPAN);
		j.phi = 13'(int'($urandom_range(TWO_PI_FX)) - PI_FX);
		j.neutral_hadron_frac = 11'($urandom_range(700));
		j.neutral_em_frac = 11'($urandom_range(700));
		j.charged_hadron_frac = 11'($urandom_range(1024));
		j.charged_em_frac = 11'($urandom_range(600));
		j.constituent_count = 8'($urandom_range(40));
		j.charged_mult = 8'($urandom_range(25));
		return j;
	endfunction

	function automatic jet_t raw_jet();
		jet_t j;
		j = '0;
		j.pt = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom);
		j.eta = 12'($urandom);
		j.phi = 13'($urandom);
		j.neutral_hadron_frac = 11'($urandom);
		j.neutral_em_frac = 11'($urandom);
		j.charged_hadron_frac = 11'($urandom);
		j.charged_em_frac = 11'($urandom);
		j.constituent_count = 8'($urandom);
		j.charged_mult = 8'($urandom);
		return j;
	endfunction

	function automatic cfg_t lenient_cuts();
		cfg_t c;
		c = '1;
		c.min_pt = '0;
		c.min_charged_hadron_frac = '0;
		c.min_constituents = '0;
		c.min_charged_mult = '0;
		return c;
	endfunction

	function automatic cfg_t random_cuts();
		cfg_t c;
		c.min_pt = 16'($urandom_range(2000));
		c.max_abs_eta = 11'($urandom_range(2047, 300));
		c.max_neutral_hadron_frac = 11'($urandom_range(2047, 300));
		c.max_neutral_em_frac = 11'($urandom_range(2047, 300));
		c.min_charged_hadron_frac = 11'($urandom_range(300));
		c.max_charged_em_frac = 11'($urandom_range(2047, 300));
		c.min_constituents = 8'($urandom_range(20));
		c.min_charged_mult = 8'($urandom_range(15));
		return c;
	endfunction

	// mostly two hard jets roughly opposite in azimuth plus soft ones, some noise
	task automatic send_random_event();
		jet_t jets[$];
		jet_t hard;
		jet_t filler;
		int kind;
		int n;
		int phi;
		kind = $urandom_range(99);
		if (kind < 75) begin
			hard = plausible_jet(2000, 30000);
			jets.push_back(hard);
			filler = plausible_jet(600, hard.pt);
			phi = $signed(hard.phi) + PI_FX + int'($urandom_range(2400)) - 1200;
			if (phi > PI_FX) begin
				phi -= TWO_PI_FX;
			end else if (phi < -PI_FX) begin
				phi += TWO_PI_FX;
			end
			filler.phi = 13'(phi);
			jets.insert($urandom_range(jets.size()), filler);
			n = $urandom_range(3);
			repeat (n) begin
				filler = plausible_jet(0, 600);
				if ($urandom_range(9) == 0) begin
					filler.pt = hard.pt;
				end
				jets.insert($urandom_range(jets.size()), filler);
			end
		end else if (kind < 90) begin
			n = $urandom_range(5, 1);
			repeat (n) jets.push_back(plausible_jet(0, 8000));
		end else begin
			n = $urandom_range(4, 1);
			repeat (n) jets.push_back(raw_jet());
		end
		foreach (jets[i]) begin
			send_jet(jets[i], i == jets.size() - 1);
		end
	endtask

	task automatic run_events(int n);
		int start;
		start = jets_sent;
		while (jets_sent - start < n) begin
			send_random_event();
		end
	endtask

	task automatic test_directed();
		jet_t a;
		jet_t b;
		idle_pct = 0;
		stall_pct = 0;
		send_jet(make_jet(1000, 0, 0), 1'b0);
		send_jet(make_jet(800, 100, PI_FX), 1'b1);
		// tie with the leader goes second, a later tie leaves the second alone
		send_jet(make_jet(900, 0, 0), 1'b0);
		send_jet(make_jet(900, 1500, PI_FX), 1'b0);
		send_jet(make_jet(900, 0, PI_FX), 1'b1);
		// zero-momentum last jet still closes the event
		send_jet(make_jet(1200, 0, 1600), 1'b0);
		send_jet(make_jet(700, 0, -1600), 1'b0);
		send_jet(make_jet(0, 0, 0), 1'b1);
		send_jet(make_jet(0, 0, 0), 1'b1);
		send_jet(make_jet(1000, 0, 0), 1'b1);
		// field extremes
		a = make_jet(65535, -2048, -4096);
		a.neutral_hadron_frac = '1;
		a.neutral_em_frac = '1;
		a.charged_hadron_frac = '1;
		a.charged_em_frac = '1;
		a.constituent_count = '1;
		a.charged_mult = '1;
		b = a;
		b.pt = 16'd65534;
		b.eta = 12'sd2047;
		b.phi = 13'sd4095;
		send_jet(a, 1'b0);
		send_jet(b, 1'b1);
		a = make_jet(65535, 1 - ETA_SPAN, -PI_FX);
		a.neutral_hadron_frac = '0;
		a.neutral_em_frac = '0;
		a.charged_hadron_frac = 11'd1024;
		a.charged_em_frac = '0;
		a.constituent_count = '1;
		a.charged_mult = '1;
		send_jet(a, 1'b0);
		send_jet(make_jet(CFG_RESET.min_pt + 1, ETA_SPAN - 1, 0), 1'b1);
		// back-to-back edge
		send_jet(make_jet(1000, 0, PI_FX - B2B_TOL), 1'b0);
		send_jet(make_jet(900, 0, 0), 1'b1);
		send_jet(make_jet(1000, 0, PI_FX - B2B_TOL + 1), 1'b0);
		send_jet(make_jet(900, 0, 0), 1'b1);
		// azimuth difference wraps
		send_jet(make_jet(1000, 0, 3000), 1'b0);
		send_jet(make_jet(900, 0, -3000), 1'b1);
		send_jet(make_jet(1000, 0, -2000), 1'b0);
		send_jet(make_jet(900, 0, 2000), 1'b1);
		// tracker edge: charged cuts apply at 614, not at 615
		a = make_jet(1000, TRACKER_ETA, 0);
		a.charged_hadron_frac = '0;
		b = make_jet(900, TRACKER_ETA + 1, PI_FX);
		b.charged_hadron_frac = '0;
		b.charged_mult = '0;
		send_jet(a, 1'b0);
		send_jet(b, 1'b1);
		a.eta = 12'(-TRACKER_ETA - 1);
		send_jet(a, 1'b0);
		send_jet(b, 1'b1);
		drain_results();
	endtask

	task automatic test_cut_extremes();
		cfg_t c;
		idle_pct = 0;
		stall_pct = 0;
		c = '0;
		write_cuts(c);
		run_events(40);
		drain_results();
		c = '1;
		write_cuts(c);
		run_events(40);
		drain_results();
		write_cuts(lenient_cuts());
		run_events(60);
		drain_results();
	endtask

	task automatic traffic_phase(int idle, int stall, cfg_t c, int n);
		write_cuts(c);
		idle_pct = idle;
		stall_pct = stall;
		run_events(n);
		drain_results();
	endtask

	task automatic test_random_traffic();
		traffic_phase(0, 0, CFG_RESET, 180);
		traffic_phase(62, 0, random_cuts(), 180);
		traffic_phase(0, 62, lenient_cuts(), 180);
		traffic_phase(36, 36, random_cuts(), 180);
	endtask

	// receiver holds off while two-jet events keep coming, so the last jet stalls
	task automatic test_backpressure();
		idle_pct = 0;
		stall_pct = 0;
		write_cuts(lenient_cuts());
		hold_left = HOLD_CYCLES;
		repeat (30) begin
			send_jet(plausible_jet(2000, 9000), 1'b0);
			send_jet(plausible_jet(600, 2000), 1'b1);
		end
		drain_results();
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		jet_pt <= '0;
		jet_eta <= '0;
		jet_phi <= '0;
		neutral_hadron_frac <= '0;
		neutral_em_frac <= '0;
		charged_hadron_frac <= '0;
		charged_em_frac <= '0;
		constituent_count <= '0;
		charged_mult <= '0;
		last_jet <= 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		hold_left = 0;
		error_count = 0;
		jets_sent = 0;
		cuts = CFG_RESET;
		lead_jet = '0;
		second_jet = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_cut_extremes();
		test_random_traffic();
		test_backpressure();
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// File: dijet_event_selector_top.f
src/dijet_pkg.sv
src/dijet_cell.sv
src/dijet_cut.sv
src/dijet_event_selector_top.sv
sim/tb_top.sv
